>>> rtl/core/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// pcsc_pkg
// Shared types, codes and helpers of the pixel color space converter.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    localparam int DivStages = 4;
    localparam int DivSteps  = 2;
    localparam int NumLanes  = 3;
    localparam int DivFirst  = 4;
    localparam int NumStages = DivFirst + DivStages + 1;
    localparam int SideDepth = NumStages - 1;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 2;

    typedef enum logic [1:0] {
        FMT_RGB  = 2'd0,
        FMT_RGBA = 2'd1,
        FMT_GRAY = 2'd2,
        FMT_CMYK = 2'd3
    } t_fmt;

    localparam logic [CfgIdxW-1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TARGET_FORMAT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LUMA_STANDARD = 2'd2;

    localparam logic [7:0] W601_R = 8'd76;
    localparam logic [7:0] W601_G = 8'd150;
    localparam logic [7:0] W601_B = 8'd29;
    localparam logic [7:0] W709_R = 8'd54;
    localparam logic [7:0] W709_G = 8'd183;
    localparam logic [7:0] W709_B = 8'd18;
    localparam logic [7:0] FULL   = 8'hff;

    // Per-pixel data that rides alongside the arithmetic stages.
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       last;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] gray;
        logic [7:0] kout;
        logic       dark;
    } t_side;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [7:0] chan3;
        logic       last;
    } t_word;

    // Division by 255 taken as (x * 257) >> 16, kept to eight bits.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [24:0] t;
        t = {1'b0, x, 8'h00} + 25'(x);
        return t[23:16];
    endfunction

endpackage

>>> rtl/core/pcsc_if.sv
// ----------------------------------------------------------------------------
// pcsc_if
// Valid/ready channels of the converter: pixel in, pixel out, configuration.
// ----------------------------------------------------------------------------
interface pcsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;
    logic [7:0] in_chan3;
    logic       in_last;

    modport source (output valid, in_chan0, in_chan1, in_chan2, in_chan3, in_last,
                    input ready);
    modport sink (input valid, in_chan0, in_chan1, in_chan2, in_chan3, in_last,
                  output ready);
endinterface

interface pcsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_chan3;
    logic       out_last;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3, out_last,
                    input ready);
    modport sink (input valid, out_chan0, out_chan1, out_chan2, out_chan3, out_last,
                  output ready);
endinterface

interface pcsc_cfg_if import pcsc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  addr;
    logic [CfgDataW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/core/pcsc_to_rgb.sv
// ----------------------------------------------------------------------------
// pcsc_to_rgb
// Two stages that bring the source pixel to RGB: ink products, then scaling.
// ----------------------------------------------------------------------------
module pcsc_to_rgb import pcsc_pkg::*; (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_fmt       i_src,
    input  logic [7:0] i_c0,
    input  logic [7:0] i_c1,
    input  logic [7:0] i_c2,
    input  logic [7:0] i_c3,
    input  t_side      i_held,
    output logic [7:0] o_r,
    output logic [7:0] o_g,
    output logic [7:0] o_b
);

    logic [15:0] r_p0, r_p1, r_p2;
    logic [15:0] n_p0, n_p1, n_p2;
    logic [7:0]  r_r, r_g, r_b;
    logic [7:0]  n_r, n_g, n_b;
    logic [7:0]  w_invk;

    assign w_invk = FULL - i_c3;
    assign n_p0   = 16'(FULL - i_c0) * 16'(w_invk);
    assign n_p1   = 16'(FULL - i_c1) * 16'(w_invk);
    assign n_p2   = 16'(FULL - i_c2) * 16'(w_invk);

    always_comb begin
        unique case (i_src)
            FMT_CMYK: begin
                n_r = div255(r_p0);
                n_g = div255(r_p1);
                n_b = div255(r_p2);
            end
            FMT_GRAY: begin
                n_r = i_held.c0;
                n_g = i_held.c0;
                n_b = i_held.c0;
            end
            FMT_RGB, FMT_RGBA: begin
                n_r = i_held.c0;
                n_g = i_held.c1;
                n_b = i_held.c2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
        if (i_en[1]) begin
            r_r <= n_r;
            r_g <= n_g;
            r_b <= n_b;
        end
    end

    assign o_r = r_r;
    assign o_g = r_g;
    assign o_b = r_b;

endmodule

>>> rtl/core/pcsc_analyze.sv
// ----------------------------------------------------------------------------
// pcsc_analyze
// Maximum and luma sum of the RGB pixel, then luma, K and the division inputs.
// ----------------------------------------------------------------------------
module pcsc_analyze import pcsc_pkg::*; (
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  t_fmt        i_src,
    input  logic        i_luma709,
    input  logic [7:0]  i_r,
    input  logic [7:0]  i_g,
    input  logic [7:0]  i_b,
    input  t_side       i_held,
    output logic [15:0] o_num [NumLanes],
    output logic [7:0]  o_den,
    output logic [7:0]  o_gray,
    output logic [7:0]  o_kout,
    output logic        o_dark
);

    logic [7:0]  r_max, n_max;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  w_wr, w_wg, w_wb;
    logic [7:0]  w_rg;

    logic [15:0] r_num [NumLanes];
    logic [15:0] n_num [NumLanes];
    logic [7:0]  r_den, r_gray, r_kout, n_gray, n_kout;
    logic        r_dark;
    logic [7:0]  w_ch [NumLanes];
    logic [7:0]  w_diff [NumLanes];

    assign w_wr = i_luma709 ? W709_R : W601_R;
    assign w_wg = i_luma709 ? W709_G : W601_G;
    assign w_wb = i_luma709 ? W709_B : W601_B;

    assign w_rg  = (i_g > i_r) ? i_g : i_r;
    assign n_max = (i_b > w_rg) ? i_b : w_rg;
    // The weights add up to 255, so the sum never leaves sixteen bits.
    assign n_sum = 16'(i_r) * 16'(w_wr) + 16'(i_g) * 16'(w_wg) + 16'(i_b) * 16'(w_wb);

    assign w_ch[0] = i_held.r;
    assign w_ch[1] = i_held.g;
    assign w_ch[2] = i_held.b;

    always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
            w_diff[l] = r_max - w_ch[l];
            n_num[l]  = {w_diff[l], 8'h00} - 16'(w_diff[l]);
        end
    end

    // A neutral CMYK pixel takes its gray straight from K.
    always_comb begin
        if (i_src == FMT_CMYK && i_held.c0 == 8'h00 && i_held.c1 == 8'h00
                && i_held.c2 == 8'h00) begin
            n_gray = FULL - i_held.c3;
        end else begin
            n_gray = div255(r_sum);
        end
    end

    assign n_kout = FULL - r_max;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_max <= n_max;
            r_sum <= n_sum;
        end
        if (i_en[1]) begin
            r_num  <= n_num;
            r_den  <= r_max;
            r_gray <= n_gray;
            r_kout <= n_kout;
            r_dark <= (r_max == 8'h00);
        end
    end

    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_gray = r_gray;
    assign o_kout = r_kout;
    assign o_dark = r_dark;

endmodule

>>> rtl/core/pcsc_divider.sv
// ----------------------------------------------------------------------------
// pcsc_divider
// Pipelined restoring divider: three lanes of a 16-bit numerator over an
// 8-bit divisor, quotient known to fit in eight bits.
// ----------------------------------------------------------------------------
module pcsc_divider import pcsc_pkg::*; (
    input  logic                 i_clk,
    input  logic [DivStages-1:0] i_en,
    input  logic [15:0]          i_num [NumLanes],
    input  logic [7:0]           i_den,
    output logic [7:0]           o_quot [NumLanes]
);

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] lo;
        logic [7:0] q;
    } t_div;

    t_div       r_st  [DivStages][NumLanes];
    t_div       n_st  [DivStages][NumLanes];
    logic [7:0] r_den [DivStages];
    logic [7:0] w_den [DivStages];

    // One bit of long division; the remainder stays below the divisor.
    function automatic t_div div_step(input t_div s, input logic [7:0] den);
        logic [8:0] t;
        logic       ge;
        t_div       o;
        t     = {s.rem, s.lo[7]};
        ge    = (t >= {1'b0, den});
        o.rem = ge ? 8'(t - {1'b0, den}) : t[7:0];
        o.lo  = {s.lo[6:0], 1'b0};
        o.q   = {s.q[6:0], ge};
        return o;
    endfunction

    always_comb begin
        for (int s = 0; s < DivStages; s++) begin
            w_den[s] = (s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1];
            for (int l = 0; l < NumLanes; l++) begin
                if (s == 0) begin
                    n_st[s][l].rem = i_num[l][15:8];
                    n_st[s][l].lo  = i_num[l][7:0];
                    n_st[s][l].q   = 8'h00;
                end else begin
                    n_st[s][l] = r_st[(s == 0) ? 0 : s - 1][l];
                end
                for (int k = 0; k < DivSteps; k++) begin
                    n_st[s][l] = div_step(n_st[s][l], w_den[s]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DivStages; s++) begin
            if (i_en[s]) begin
                r_st[s]  <= n_st[s];
                r_den[s] <= w_den[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
            o_quot[l] = r_st[DivStages-1][l].q;
        end
    end

endmodule

>>> rtl/core/pcsc_pack.sv
// ----------------------------------------------------------------------------
// pcsc_pack
// Output register: assembles the result word in the target format.
// ----------------------------------------------------------------------------
module pcsc_pack import pcsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_fmt       i_src,
    input  t_fmt       i_tgt,
    input  t_side      i_side,
    input  logic [7:0] i_quot [NumLanes],
    output t_word      o_word
);

    t_word r_word, n_word;

    always_comb begin
        n_word      = '0;
        n_word.last = i_side.last;
        if (i_src == i_tgt) begin
            n_word.chan0 = i_side.c0;
            if (i_src != FMT_GRAY) begin
                n_word.chan1 = i_side.c1;
                n_word.chan2 = i_side.c2;
            end
            if (i_src == FMT_RGBA || i_src == FMT_CMYK) begin
                n_word.chan3 = i_side.c3;
            end
        end else begin
            unique case (i_tgt)
                FMT_RGB, FMT_RGBA: begin
                    n_word.chan0 = i_side.r;
                    n_word.chan1 = i_side.g;
                    n_word.chan2 = i_side.b;
                    if (i_tgt == FMT_RGBA) begin
                        n_word.chan3 = FULL;
                    end
                end
                FMT_GRAY: begin
                    n_word.chan0 = i_side.gray;
                end
                FMT_CMYK: begin
                    // A gray source has equal channels, so its quotients are zero.
                    n_word.chan3 = i_side.kout;
                    if (!i_side.dark) begin
                        n_word.chan0 = i_quot[0];
                        n_word.chan1 = i_quot[1];
                        n_word.chan2 = i_quot[2];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> rtl/core/pixel_color_space_converter.sv
// Throughput: one word per cycle; a stalled output fills bubbles first.
// The pipeline has nine stages, four of them the divider.
// Reset clears all stage valid bits and returns the configuration to
// rgb source, rgba target and Rec.601 luma.
// ----------------------------------------------------------------------------
// pixel_color_space_converter
// Converts one 8-bit pixel per word between RGB, RGBA, grayscale and CMYK.
// ----------------------------------------------------------------------------
module pixel_color_space_converter import pcsc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcsc_in_if.sink       i_pix,
    pcsc_out_if.source    o_pix,
    pcsc_cfg_if.sink      i_cfg
);

    t_fmt                 r_src, r_tgt;
    logic                 r_luma709;
    logic [NumStages-1:0] r_valid;
    logic [NumStages-1:0] w_adv;
    t_side                r_side [SideDepth];
    t_side                n_side [SideDepth];

    logic [7:0]  w_r, w_g, w_b;
    logic [15:0] w_num [NumLanes];
    logic [7:0]  w_den, w_gray, w_kout;
    logic        w_dark;
    logic [7:0]  w_quot [NumLanes];
    t_word       w_word;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src     <= FMT_RGB;
            r_tgt     <= FMT_RGBA;
            r_luma709 <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.addr)
                CFG_SOURCE_FORMAT: r_src     <= t_fmt'(i_cfg.data);
                CFG_TARGET_FORMAT: r_tgt     <= t_fmt'(i_cfg.data);
                CFG_LUMA_STANDARD: r_luma709 <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        w_adv[NumStages-1] = !r_valid[NumStages-1] || o_pix.ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    assign i_pix.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_adv[0]) begin
                r_valid[0] <= i_pix.valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Side data line; results of the RGB and analysis stages join it.
    always_comb begin
        n_side[0]      = '0;
        n_side[0].c0   = i_pix.in_chan0;
        n_side[0].c1   = i_pix.in_chan1;
        n_side[0].c2   = i_pix.in_chan2;
        n_side[0].c3   = i_pix.in_chan3;
        n_side[0].last = i_pix.in_last;
        for (int k = 1; k < SideDepth; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[2].r         = w_r;
        n_side[2].g         = w_g;
        n_side[2].b         = w_b;
        n_side[DivFirst].gray = w_gray;
        n_side[DivFirst].kout = w_kout;
        n_side[DivFirst].dark = w_dark;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SideDepth; k++) begin
            if (w_adv[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    pcsc_to_rgb u_to_rgb (
        .i_clk  (i_clk),
        .i_en   (w_adv[1:0]),
        .i_src  (r_src),
        .i_c0   (i_pix.in_chan0),
        .i_c1   (i_pix.in_chan1),
        .i_c2   (i_pix.in_chan2),
        .i_c3   (i_pix.in_chan3),
        .i_held (r_side[0]),
        .o_r    (w_r),
        .o_g    (w_g),
        .o_b    (w_b)
    );

    pcsc_analyze u_analyze (
        .i_clk     (i_clk),
        .i_en      (w_adv[3:2]),
        .i_src     (r_src),
        .i_luma709 (r_luma709),
        .i_r       (w_r),
        .i_g       (w_g),
        .i_b       (w_b),
        .i_held    (r_side[2]),
        .o_num     (w_num),
        .o_den     (w_den),
        .o_gray    (w_gray),
        .o_kout    (w_kout),
        .o_dark    (w_dark)
    );

    pcsc_divider u_divider (
        .i_clk  (i_clk),
        .i_en   (w_adv[DivFirst+DivStages-1:DivFirst]),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_quot (w_quot)
    );

    pcsc_pack u_pack (
        .i_clk  (i_clk),
        .i_en   (w_adv[NumStages-1]),
        .i_src  (r_src),
        .i_tgt  (r_tgt),
        .i_side (r_side[SideDepth-1]),
        .i_quot (w_quot),
        .o_word (w_word)
    );

    assign o_pix.valid     = r_valid[NumStages-1];
    assign o_pix.out_chan0 = w_word.chan0;
    assign o_pix.out_chan1 = w_word.chan1;
    assign o_pix.out_chan2 = w_word.chan2;
    assign o_pix.out_chan3 = w_word.chan3;
    assign o_pix.out_last  = w_word.last;

endmodule

>>> rtl/core/pcsc_checker.sv
// ----------------------------------------------------------------------------
// pcsc_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pcsc_checker import pcsc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_chan0,
    input logic [7:0] i_out_chan1,
    input logic [7:0] i_out_chan2,
    input logic [7:0] i_out_chan3,
    input logic       i_out_last,
    input logic       i_cfg_valid,
    input logic       i_cfg_ready
);

    logic [3:0] r_cnt;
    logic       w_in_fire, w_out_fire;

    assign w_in_fire  = i_in_valid && i_in_ready;
    assign w_out_fire = i_out_valid && i_out_ready;

    // Words accepted whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_fire && !w_out_fire) begin
            r_cnt <= r_cnt + 4'd1;
        end else if (w_out_fire && !w_in_fire) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_out_chan0, i_out_chan1, i_out_chan2, i_out_chan3, i_out_last}))
        else $error("output word changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |-> r_cnt != 4'd0)
        else $error("output word without an accepted input word");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 4'd0 |-> i_in_ready && i_cfg_ready)
        else $error("empty converter refuses a word");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && !w_out_fire |-> r_cnt < 4'(NumStages))
        else $error("more words in flight than pipeline stages");

endmodule

bind pixel_color_space_converter pcsc_checker u_pcsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_chan0 (o_pix.out_chan0),
    .i_out_chan1 (o_pix.out_chan1),
    .i_out_chan2 (o_pix.out_chan2),
    .i_out_chan3 (o_pix.out_chan3),
    .i_out_last  (o_pix.out_last),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Pixel color space converter test: drives pixel words and register writes
// over valid/ready channels, predicts every result word from a local model of
// the format conversion and compares each output word in order.
// ----------------------------------------------------------------------------
module testbench;
    import pcsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;

    pcsc_in_if  pix_in ();
    pcsc_out_if pix_out ();
    pcsc_cfg_if cfg_wr ();

    pixel_color_space_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_wr)
    );

    // Local copy of the configuration, starting from the reset values.
    t_fmt cur_src    = FMT_RGB;
    t_fmt cur_dst    = FMT_RGBA;
    logic cur_rec709 = 1'b0;

    t_word expected_pixels[$];
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    in_idle_pct    = 0;
    int    out_idle_pct   = 0;
    logic  hold_off       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] over_255(int unsigned x);
        return 8'((x * 257) >> 16);
    endfunction

    function automatic logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned sum;
        if (cur_rec709)
            sum = r * 54 + g * 183 + b * 18;
        else
            sum = r * 76 + g * 150 + b * 29;
        return over_255(sum);
    endfunction

    function automatic logic [7:0] ink_of(logic [7:0] mx, logic [7:0] chan);
        int unsigned num;
        num = (int'(mx) - int'(chan)) * 255;
        return 8'(num / int'(mx));
    endfunction

    function automatic t_word convert_pixel(t_word px);
        t_word       o;
        logic [7:0]  r, g, b, mx;
        int unsigned inv_k;
        o      = '0;
        o.last = px.last;
        if (cur_src == cur_dst) begin
            o.chan0 = px.chan0;
            if (cur_src != FMT_GRAY) begin
                o.chan1 = px.chan1;
                o.chan2 = px.chan2;
            end
            if (cur_src == FMT_RGBA || cur_src == FMT_CMYK)
                o.chan3 = px.chan3;
            return o;
        end
        case (cur_src)
            FMT_GRAY: begin
                r = px.chan0;
                g = px.chan0;
                b = px.chan0;
            end
            FMT_CMYK: begin
                inv_k = 255 - int'(px.chan3);
                r = over_255((255 - int'(px.chan0)) * inv_k);
                g = over_255((255 - int'(px.chan1)) * inv_k);
                b = over_255((255 - int'(px.chan2)) * inv_k);
            end
            default: begin
                r = px.chan0;
                g = px.chan1;
                b = px.chan2;
            end
        endcase
        case (cur_dst)
            FMT_RGB, FMT_RGBA: begin
                o.chan0 = r;
                o.chan1 = g;
                o.chan2 = b;
                if (cur_dst == FMT_RGBA)
                    o.chan3 = 8'hff;
            end
            FMT_GRAY: begin
                // A CMYK pixel without ink is neutral: gray comes from K alone.
                if (cur_src == FMT_CMYK && px.chan0 == 0 && px.chan1 == 0 && px.chan2 == 0)
                    o.chan0 = 8'hff - px.chan3;
                else
                    o.chan0 = luma(r, g, b);
            end
            default: begin
                if (cur_src == FMT_GRAY) begin
                    o.chan3 = 8'hff - px.chan0;
                end else begin
                    mx = r;
                    if (g > mx) mx = g;
                    if (b > mx) mx = b;
                    o.chan3 = 8'hff - mx;
                    if (mx != 0) begin
                        o.chan0 = ink_of(mx, r);
                        o.chan1 = ink_of(mx, g);
                        o.chan2 = ink_of(mx, b);
                    end
                end
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && pix_in.valid && pix_in.ready)
            expected_pixels.push_back(convert_pixel('{pix_in.in_chan0, pix_in.in_chan1,
                                                      pix_in.in_chan2, pix_in.in_chan3,
                                                      pix_in.in_last}));
    end

    always @(posedge i_clk) begin : check_output
        t_word got;
        t_word want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            got = '{pix_out.out_chan0, pix_out.out_chan1, pix_out.out_chan2,
                    pix_out.out_chan3, pix_out.out_last};
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output word %h %h %h %h last %b",
                             got.chan0, got.chan1, got.chan2, got.chan3, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got.chan0 !== want.chan0 || got.chan1 !== want.chan1 ||
                    got.chan2 !== want.chan2 || got.chan3 !== want.chan3 ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch src %s dst %s: expected %h %h %h %h last %b, got %h %h %h %h last %b",
                                 cur_src.name(), cur_dst.name(),
                                 want.chan0, want.chan1, want.chan2, want.chan3, want.last,
                                 got.chan0, got.chan1, got.chan2, got.chan3, got.last);
                end
            end
        end
    end

    // Output ready: random stalls, or held low during a forced hold-off.
    initial begin
        pix_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off)
                pix_out.ready <= 1'b0;
            else
                pix_out.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(t_word px);
        while ($urandom_range(99) < in_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.in_chan0 <= px.chan0;
        pix_in.in_chan1 <= px.chan1;
        pix_in.in_chan2 <= px.chan2;
        pix_in.in_chan3 <= px.chan3;
        pix_in.in_last  <= px.last;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_wr.valid <= 1'b1;
        cfg_wr.addr  <= idx;
        cfg_wr.data  <= val;
        do @(posedge i_clk); while (!cfg_wr.ready);
        case (idx)
            CFG_SOURCE_FORMAT: cur_src    = t_fmt'(val[1:0]);
            CFG_TARGET_FORMAT: cur_dst    = t_fmt'(val[1:0]);
            CFG_LUMA_STANDARD: cur_rec709 = val[0];
            default: ;
        endcase
        cfg_wr.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(t_fmt src, t_fmt dst, logic rec709);
        wait_idle();
        write_reg(CFG_SOURCE_FORMAT, CfgDataW'(src));
        write_reg(CFG_TARGET_FORMAT, CfgDataW'(dst));
        write_reg(CFG_LUMA_STANDARD, CfgDataW'(rec709));
    endtask

    function automatic logic [7:0] random_chan();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_word random_pixel();
        t_word px;
        px.chan0 = random_chan();
        px.chan1 = random_chan();
        px.chan2 = random_chan();
        px.chan3 = random_chan();
        px.last  = 1'($urandom_range(1));
        // Steer some words into black RGB / ink-free CMYK and into equal channels.
        case ($urandom_range(7))
            0: begin
                px.chan0 = 8'h00;
                px.chan1 = 8'h00;
                px.chan2 = 8'h00;
            end
            1: begin
                px.chan1 = px.chan0;
                px.chan2 = px.chan0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_pixel('{8'h12, 8'h34, 8'h56, 8'h00, 1'b0});
        send_pixel('{8'hff, 8'h00, 8'hff, 8'h9c, 1'b1});
    endtask

    task automatic test_format_pairs();
        set_config(FMT_RGB, FMT_RGB, 1'b0);
        send_pixel('{8'h12, 8'h34, 8'h56, 8'hab, 1'b0});
        set_config(FMT_RGBA, FMT_RGBA, 1'b0);
        send_pixel('{8'hff, 8'h00, 8'h80, 8'h5a, 1'b1});
        set_config(FMT_GRAY, FMT_GRAY, 1'b1);
        send_pixel('{8'hc3, 8'h11, 8'h22, 8'h33, 1'b0});
        set_config(FMT_CMYK, FMT_CMYK, 1'b0);
        send_pixel('{8'h01, 8'h02, 8'h03, 8'hfe, 1'b1});
        set_config(FMT_RGB, FMT_RGBA, 1'b0);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'h00, 1'b1});
        set_config(FMT_RGBA, FMT_RGB, 1'b1);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'hff, 1'b0});
        set_config(FMT_RGB, FMT_GRAY, 1'b0);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'h7f, 1'b0});
        send_pixel('{8'hff, 8'h00, 8'h00, 8'h00, 1'b1});
        set_config(FMT_RGBA, FMT_GRAY, 1'b1);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 1'b0});
        send_pixel('{8'h00, 8'hff, 8'h00, 8'h00, 1'b1});
        // Black input has no maximum to divide by.
        set_config(FMT_RGB, FMT_CMYK, 1'b0);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'hff, 1'b1});
        send_pixel('{8'hff, 8'h80, 8'h00, 8'h00, 1'b0});
        set_config(FMT_RGBA, FMT_CMYK, 1'b1);
        send_pixel('{8'h01, 8'h02, 8'h03, 8'h10, 1'b1});
        send_pixel('{8'h40, 8'h40, 8'h40, 8'h00, 1'b0});
        set_config(FMT_GRAY, FMT_RGB, 1'b0);
        send_pixel('{8'h80, 8'hff, 8'hff, 8'hff, 1'b0});
        set_config(FMT_GRAY, FMT_RGBA, 1'b1);
        send_pixel('{8'hff, 8'h00, 8'h00, 8'h00, 1'b1});
        set_config(FMT_GRAY, FMT_CMYK, 1'b0);
        send_pixel('{8'h00, 8'h5a, 8'ha5, 8'h3c, 1'b1});
        send_pixel('{8'hff, 8'h00, 8'h00, 8'h00, 1'b0});
        // Ink-free CMYK takes its gray from K, inked CMYK goes through luma.
        set_config(FMT_CMYK, FMT_GRAY, 1'b0);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h4d, 1'b0});
        send_pixel('{8'h10, 8'h20, 8'h30, 8'h40, 1'b1});
        set_config(FMT_CMYK, FMT_GRAY, 1'b1);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
        set_config(FMT_CMYK, FMT_RGB, 1'b0);
        send_pixel('{8'h00, 8'h00, 8'h00, 8'hff, 1'b0});
        send_pixel('{8'hff, 8'hff, 8'hff, 8'h00, 1'b1});
        set_config(FMT_CMYK, FMT_RGBA, 1'b1);
        send_pixel('{8'h20, 8'h40, 8'h60, 8'h80, 1'b0});
    endtask

    task automatic test_random_stream();
        int offset;
        int combo;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin in_idle_pct = 38; out_idle_pct = 71; end
                1: begin in_idle_pct = 71; out_idle_pct = 38; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            offset = $urandom_range(31);
            for (int k = 0; k < 32; k++) begin
                combo = (k + offset) % 32;
                set_config(t_fmt'(combo[1:0]), t_fmt'(combo[3:2]), combo[4]);
                repeat ($urandom_range(26, 14)) send_pixel(random_pixel());
            end
        end
    endtask

    task automatic test_output_backpressure();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_config(FMT_RGB, FMT_CMYK, 1'b1);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (60) send_pixel(random_pixel());
        join
    endtask

    initial begin
        i_rst_n         = 1'b0;
        pix_in.valid    = 1'b0;
        pix_in.in_chan0 = '0;
        pix_in.in_chan1 = '0;
        pix_in.in_chan2 = '0;
        pix_in.in_chan3 = '0;
        pix_in.in_last  = 1'b0;
        cfg_wr.valid    = 1'b0;
        cfg_wr.addr     = '0;
        cfg_wr.data     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_format_pairs();
        test_random_stream();
        test_output_backpressure();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            $display("%0d expected words never arrived", expected_pixels.size());
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
